>>> rtl/core/etg_pkg.sv
`timescale 1ns / 1ps
// shared constants, register indexes and sine table math for the tone generator
package etg_pkg;

  localparam int SINE_ENTRIES_DEF = 256;
  localparam int PHASE_BITS_DEF   = 32;

  // configuration register indexes
  localparam logic [1:0] REG_AMPLITUDE    = 2'd0;
  localparam logic [1:0] REG_ATTACK_POINT = 2'd1;
  localparam logic [1:0] REG_DECAY_DEPTH  = 2'd2;

  // register reset values
  localparam logic [14:0] AMPLITUDE_RST    = 15'd8000;
  localparam logic [15:0] ATTACK_POINT_RST = 16'd9830;
  localparam logic [15:0] DECAY_DEPTH_RST  = 16'd39322;

  // pi/2 in q30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // q48 reciprocals of the taylor divisors (2n)(2n+1), rounded up so the
  // quotient is exact for any term below 2^40
  localparam logic [63:0] TAYLOR_RECIP_Q48 [1:7] = '{
    (64'd1 << 48) / 64'd6   + 64'd1,
    (64'd1 << 48) / 64'd20  + 64'd1,
    (64'd1 << 48) / 64'd42  + 64'd1,
    (64'd1 << 48) / 64'd72  + 64'd1,
    (64'd1 << 48) / 64'd110 + 64'd1,
    (64'd1 << 48) / 64'd156 + 64'd1,
    (64'd1 << 48) / 64'd210 + 64'd1
  };

  // q15 sine of a q30 angle by a fixed-point taylor series, elaboration only
  function automatic logic [15:0] sine_q15(input logic [63:0] x);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [127:0] wide;
    sum  = x;
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      wide = 128'(term) * 128'(TAYLOR_RECIP_Q48[n]);
      term = wide[111:48];
      if (n[0] == 1'b1) begin
        sum = (sum >= term) ? sum - term : 64'd0;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'd16384) >> 15;
    return (sum > 64'd32768) ? 16'd32768 : sum[15:0];
  endfunction

endpackage

>>> rtl/core/enveloped_tone_generator_top.sv
`timescale 1ns / 1ps
// sine tone generator with linear attack / decay envelope, iterative datapath
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  in       | in_tvalid / in_tready  | in_tuser: command, in_tdata: step, length
//  out      | out_tvalid / out_tready| out_tdata: sample, out_tlast: note done
//  cfg      | cfg_we (no wait)       | cfg_addr: register index, cfg_wdata: value
//
//  a sounding tick, from accept to the next accept, runs two 16-step restoring
//  divisions (note progress, envelope) and three passes (four in the decay segment)
//  through the one 32x17 multiplier, all run by one sequencer
//  a silent tick (note ended or never started) goes from idle straight to output
//  in_tready is high only while the sequencer idles; a finished sample sits in the
//  output register so the next transaction is taken even while out is stalled
//  rst_n is synchronous, active low; it clears the note state and loads the
//  register defaults
module enveloped_tone_generator_top #(
  parameter int SINE_ENTRIES = etg_pkg::SINE_ENTRIES_DEF,
  parameter int PHASE_BITS   = etg_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input transactions
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [30:0] phase_step, [46:31] note_length, [47] zero
  input  logic        in_tuser,   // [0] command: 0 next sample, 1 start note
  // result transactions
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] sample, two's complement
  output logic        out_tlast,  // note_done
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);
  import etg_pkg::*;

  localparam int QuarterShift = PHASE_BITS - 2;
  localparam int StepW        = (PHASE_BITS < 31) ? PHASE_BITS : 31;
  localparam int AddrW        = $clog2(SINE_ENTRIES + 1);

  typedef logic [15:0] rom_t [SINE_ENTRIES + 1];

  function automatic rom_t build_rom();
    rom_t tab;
    for (int k = 0; k <= SINE_ENTRIES; k++) begin
      tab[k] = sine_q15(64'(k) * HALF_PI_Q30 / 64'(SINE_ENTRIES));
    end
    return tab;
  endfunction

  localparam rom_t SineRom = build_rom();

  typedef enum logic [3:0] {
    S_IDLE,
    S_IDX_MUL,   // quarter phase times table size
    S_ROM,       // table read, start progress division
    S_P_DIV,     // progress = index * 65536 / length
    S_ENV_SEL,   // pick attack or decay segment
    S_DEC_MUL,   // decay_depth * (p - attack_point)
    S_DEC_LOAD,  // start decay division
    S_ENV_DIV,   // envelope division
    S_AMP_MUL,   // magnitude * amplitude
    S_ENV_LOAD,  // load envelope product operands
    S_ENV_MUL,   // (magnitude * amplitude) * envelope
    S_SIGN,      // scale, apply quadrant sign, advance note
    S_OUT        // hand result to the output register
  } state_t;

  state_t state_r;

  // configuration
  logic [14:0] amplitude_r;
  logic [15:0] attack_point_r;
  logic [15:0] decay_depth_r;

  // note state
  logic [PHASE_BITS-1:0] phase_r;
  logic [15:0]           index_r;
  logic [15:0]           length_r;
  logic [StepW-1:0]      step_r;

  // datapath
  logic [31:0] mul_a_r;
  logic [16:0] mul_b_r;
  logic [48:0] mul_p_r;
  logic [15:0] mag_r;
  logic [15:0] p_r;
  logic        attack_r;
  logic [16:0] env_r;
  logic [16:0] div_rem_r;
  logic [15:0] div_quo_r;
  logic [16:0] div_den_r;
  logic [3:0]  div_cnt_r;
  logic [15:0] res_sample_r;
  logic        res_done_r;

  // output register
  logic        out_valid_r;
  logic [15:0] out_sample_r;
  logic        out_done_r;

  // restoring divider step, one quotient bit per cycle
  logic [17:0] div_trial;
  logic [17:0] div_diff;
  logic        div_ge;
  logic [16:0] div_rem_nxt;
  logic [15:0] div_quo_nxt;

  always_comb begin
    div_trial   = {div_rem_r, div_quo_r[15]};
    div_diff    = div_trial - {1'b0, div_den_r};
    div_ge      = (div_trial >= {1'b0, div_den_r});
    div_rem_nxt = div_ge ? div_diff[16:0] : div_trial[16:0];
    div_quo_nxt = {div_quo_r[14:0], div_ge};
  end

  // effective note state of an accepted transaction
  logic                  in_fire;
  logic [15:0]           len_e;
  logic [15:0]           idx_e;
  logic [PHASE_BITS-1:0] ph_e;

  // table address from the scaled quarter phase
  logic [AddrW-1:0] rom_idx;
  logic [AddrW-1:0] rom_addr;

  // final magnitude
  logic [14:0] mag_out;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign len_e     = in_tuser ? in_tdata[46:31] : length_r;
  assign idx_e     = in_tuser ? 16'd0 : index_r;
  assign ph_e      = in_tuser ? '0 : phase_r;
  assign rom_idx   = mul_p_r[QuarterShift +: AddrW];
  assign rom_addr  = phase_r[QuarterShift] ? AddrW'(SINE_ENTRIES) - rom_idx : rom_idx;
  assign mag_out   = mul_p_r[45:31];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_sample_r;
  assign out_tlast  = out_done_r;

  always_ff @(posedge clk) begin
    mul_p_r <= 49'(mul_a_r) * 49'(mul_b_r);
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      amplitude_r    <= AMPLITUDE_RST;
      attack_point_r <= ATTACK_POINT_RST;
      decay_depth_r  <= DECAY_DEPTH_RST;
      phase_r        <= '0;
      index_r        <= 16'd0;
      length_r       <= 16'd0;
      step_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_AMPLITUDE:    amplitude_r    <= cfg_wdata[14:0];
          REG_ATTACK_POINT: attack_point_r <= cfg_wdata;
          REG_DECAY_DEPTH:  decay_depth_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // a result waiting in S_OUT refills the register in the same cycle
      if (out_valid_r && out_tready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_tuser) begin
              step_r   <= in_tdata[StepW-1:0];
              length_r <= in_tdata[46:31];
              phase_r  <= '0;
              index_r  <= 16'd0;
            end
            if (idx_e >= len_e) begin
              // note over: silence, state frozen
              res_sample_r <= 16'd0;
              res_done_r   <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              mul_a_r <= 32'(ph_e[QuarterShift-1:0]);
              mul_b_r <= 17'(SINE_ENTRIES);
              state_r <= S_IDX_MUL;
            end
          end
        end
        S_IDX_MUL: begin
          state_r <= S_ROM;
        end
        S_ROM: begin
          // dividend is index * 65536, index below length keeps the quotient in 16 bits
          mag_r     <= SineRom[rom_addr];
          div_rem_r <= {1'b0, index_r};
          div_quo_r <= 16'd0;
          div_den_r <= {1'b0, length_r};
          div_cnt_r <= 4'd15;
          state_r   <= S_P_DIV;
        end
        S_P_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - 4'd1;
          if (div_cnt_r == 4'd0) begin
            p_r     <= div_quo_nxt;
            state_r <= S_ENV_SEL;
          end
        end
        S_ENV_SEL: begin
          if (p_r < attack_point_r) begin
            // attack segment: p * 65536 / attack_point
            attack_r  <= 1'b1;
            div_rem_r <= {1'b0, p_r};
            div_quo_r <= 16'd0;
            div_den_r <= {1'b0, attack_point_r};
            div_cnt_r <= 4'd15;
            state_r   <= S_ENV_DIV;
          end else begin
            attack_r <= 1'b0;
            mul_a_r  <= 32'(decay_depth_r);
            mul_b_r  <= 17'(p_r - attack_point_r);
            state_r  <= S_DEC_MUL;
          end
        end
        S_DEC_MUL: begin
          state_r <= S_DEC_LOAD;
        end
        S_DEC_LOAD: begin
          div_rem_r <= {1'b0, mul_p_r[31:16]};
          div_quo_r <= mul_p_r[15:0];
          div_den_r <= 17'h10000 - {1'b0, attack_point_r};
          div_cnt_r <= 4'd15;
          state_r   <= S_ENV_DIV;
        end
        S_ENV_DIV: begin
          div_rem_r <= div_rem_nxt;
          div_quo_r <= div_quo_nxt;
          div_cnt_r <= div_cnt_r - 4'd1;
          if (div_cnt_r == 4'd0) begin
            env_r   <= attack_r ? {1'b0, div_quo_nxt} : 17'h10000 - {1'b0, div_quo_nxt};
            mul_a_r <= 32'(mag_r);
            mul_b_r <= {2'b00, amplitude_r};
            state_r <= S_AMP_MUL;
          end
        end
        S_AMP_MUL: begin
          state_r <= S_ENV_LOAD;
        end
        S_ENV_LOAD: begin
          mul_a_r <= mul_p_r[31:0];
          mul_b_r <= env_r;
          state_r <= S_ENV_MUL;
        end
        S_ENV_MUL: begin
          state_r <= S_SIGN;
        end
        S_SIGN: begin
          // upper quadrant bit gives the negative half wave
          res_sample_r <= phase_r[PHASE_BITS-1] ? 16'd0 - {1'b0, mag_out} : {1'b0, mag_out};
          res_done_r   <= ((index_r + 16'd1) == length_r);
          index_r      <= index_r + 16'd1;
          phase_r      <= phase_r + PHASE_BITS'(step_r);
          state_r      <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_sample_r;
            out_done_r   <= res_done_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> verif/etg_tone_checker.sv
`timescale 1ns / 1ps
// checker for the tone generator: mirrors its registers, predicts each sample and compares
module etg_tone_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,   // [30:0] phase_step, [46:31] note_length, [47] zero
  input  logic        in_tuser,   // [0] command
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // [15:0] sample
  input  logic        out_tlast,  // note_done
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [15:0] cfg_wdata,
  output int          errors,
  output int          pending
);
  import etg_pkg::*;

  localparam int SINE_N = SINE_ENTRIES_DEF;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [15:0] sample;
    logic        done;
  } tone_out_t;

  int unsigned sine_rom [0:SINE_N];

  logic [14:0] amp_q;
  logic [15:0] atk_q;
  logic [15:0] depth_q;
  logic [31:0] ph_acc;
  logic [15:0] tick_idx;
  logic [15:0] note_len;
  logic [30:0] note_step;

  tone_out_t samples_due[$];

  // q15 quarter-wave sine of a q30 angle, taylor series up to the 15th power
  function automatic int unsigned quarter_sine_q15(input longint unsigned ang);
    longint unsigned acc;
    longint unsigned t;
    acc = ang;
    t   = ang;
    for (int k = 1; k <= 7; k++) begin
      t = (((t * ang) >> 30) * ang) >> 30;
      t = t / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        acc = (acc >= t) ? acc - t : 64'd0;
      end else begin
        acc = acc + t;
      end
    end
    acc = (acc + 64'd16384) >> 15;
    return (acc > 64'd32768) ? 32768 : int'(acc);
  endfunction

  // one tick: optional note start, then the enveloped sample and the done flag
  function automatic tone_out_t next_tone_sample(input logic start_note,
                                                 input logic [30:0] step,
                                                 input logic [15:0] len);
    tone_out_t   r;
    logic [1:0]  quad;
    int unsigned tidx;
    int unsigned mag;
    int unsigned prog;
    int unsigned env;
    longint unsigned prod;
    logic [15:0] m;
    if (start_note) begin
      note_step = step;
      note_len  = len;
      ph_acc    = '0;
      tick_idx  = '0;
    end
    if (tick_idx >= note_len) begin
      r.sample = '0;
      r.done   = 1'b1;
      return r;
    end
    quad = ph_acc[31:30];
    tidx = int'((u64_t'(ph_acc[29:0]) * SINE_N) >> 30);
    if (tidx > SINE_N) tidx = SINE_N;
    mag = quad[0] ? sine_rom[SINE_N - tidx] : sine_rom[tidx];
    prog = int'((u64_t'(tick_idx) << 16) / note_len);
    if (prog < atk_q) begin
      env = int'((u64_t'(prog) << 16) / atk_q);
    end else begin
      env = 65536 - int'((u64_t'(depth_q) * (prog - atk_q)) / (65536 - atk_q));
    end
    prod = (u64_t'(mag) * amp_q * env) >> 31;
    m = prod[15:0];
    r.sample = quad[1] ? -m : m;
    r.done   = (tick_idx + 1 == note_len);
    tick_idx = tick_idx + 16'd1;
    ph_acc   = ph_acc + {1'b0, note_step};
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 200) $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  initial begin
    errors  = 0;
    pending = 0;
    for (int k = 0; k <= SINE_N; k++) begin
      sine_rom[k] = quarter_sine_q15(longint'(k) * HALF_PI_Q30 / SINE_N);
    end
  end

  always @(posedge clk) begin
    tone_out_t want;
    if (!rst_n) begin
      amp_q     = AMPLITUDE_RST;
      atk_q     = ATTACK_POINT_RST;
      depth_q   = DECAY_DEPTH_RST;
      ph_acc    = '0;
      tick_idx  = '0;
      note_len  = '0;
      note_step = '0;
      samples_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_AMPLITUDE:    amp_q   = cfg_wdata[14:0];
          REG_ATTACK_POINT: atk_q   = cfg_wdata;
          REG_DECAY_DEPTH:  depth_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        samples_due.push_back(next_tone_sample(in_tuser, in_tdata[30:0], in_tdata[46:31]));
      end
      if (out_tvalid && out_tready) begin
        if (samples_due.size() == 0) begin
          report_mismatch($sformatf("unexpected sample %0d done %0b",
                                    $signed(out_tdata), out_tlast));
        end else begin
          want = samples_due.pop_front();
          if (out_tdata !== want.sample) begin
            report_mismatch($sformatf("sample %0d, expected %0d",
                                      $signed(out_tdata), $signed(want.sample)));
          end
          if (out_tlast !== want.done) begin
            report_mismatch($sformatf("note_done %0b, expected %0b", out_tlast, want.done));
          end
        end
      end
    end
    pending <= samples_due.size();
  end

endmodule

>>> verif/tb_enveloped_tone_generator_top.sv
`timescale 1ns / 1ps
// testbench top for the tone generator: stimulus, register programming and verdict
module tb_enveloped_tone_generator_top;
  import etg_pkg::*;

  // command codes carried in in_tuser
  localparam logic CMD_NEXT  = 1'b0;
  localparam logic CMD_START = 1'b1;
  // register index with no register behind it, writes must be dropped
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam int ITEMS_PER_PHASE = 96;
  localparam int RANDOM_PHASES   = 6;
  localparam int LONG_HOLD       = 400;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // [30:0] phase_step, [46:31] note_length, [47] zero
  logic        in_tuser;   // [0] command
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [15:0] sample
  logic        out_tlast;  // note_done
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [15:0] cfg_wdata;

  int errors;
  int pending;
  int items;

  // idle percentages for each side, changed per phase
  int tx_idle_pct;
  int rx_idle_pct;

  // long receiver hold-off: request from the stimulus, count kept by the receiver
  bit hold_req;
  int hold_left;

  enveloped_tone_generator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  etg_tone_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one input transaction; sender gaps come first so valid never drops and rises in one step
  task automatic send_tick(input logic cmd, input logic [30:0] step, input logic [15:0] len);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, len, step};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items++;
  endtask

  // next-sample tick, the step and length fields carry junk the block must ignore
  task automatic send_next();
    send_tick(CMD_NEXT, 31'($urandom()), 16'($urandom()));
  endtask

  // wait until every expected sample is back and the block is quiet
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // back-to-back register writes, the spare index gets junk
  task automatic program_regs(input logic [15:0] amp, input logic [15:0] atk,
                              input logic [15:0] depth);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_AMPLITUDE;
    cfg_wdata <= amp;
    @(posedge clk);
    cfg_addr  <= REG_ATTACK_POINT;
    cfg_wdata <= atk;
    @(posedge clk);
    cfg_addr  <= REG_DECAY_DEPTH;
    cfg_wdata <= depth;
    @(posedge clk);
    cfg_addr  <= REG_SPARE;
    cfg_wdata <= 16'($urandom());
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // half the time an extreme, otherwise anything a 16-bit write can carry
  function automatic logic [15:0] pick_reg_value(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(3))
      0: return lo;
      1: return hi;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // a well-formed note: start, play it to the end (short notes) and up to two ticks past it
  task automatic send_note();
    int          r;
    int          ticks;
    logic [15:0] len;
    logic [30:0] step;
    r = $urandom_range(99);
    if (r < 80) begin
      len = 16'($urandom_range(40, 1));
    end else if (r < 95) begin
      len = 16'($urandom_range(65535));
    end else begin
      len = $urandom_range(1) ? 16'd0 : 16'hFFFF;
    end
    r = $urandom_range(99);
    if (r < 70) begin
      step = 31'($urandom());
    end else if (r < 90) begin
      step = 31'($urandom_range(32'h0100_0000));
    end else begin
      step = $urandom_range(1) ? 31'd0 : 31'h7FFF_FFFF;
    end
    // long notes are only sampled at their start, ending them would take too long
    ticks = (len > 48) ? $urandom_range(20) : int'(len) - 1 + $urandom_range(2);
    if (ticks < 0) ticks = 0;
    send_tick(CMD_START, step, len);
    repeat (ticks) send_next();
  endtask

  initial begin
    // every input known from time zero
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = CMD_NEXT;
    out_tready  = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = REG_AMPLITUDE;
    cfg_wdata   = '0;
    hold_req    = 1'b0;
    hold_left   = 0;
    items       = 0;
    tx_idle_pct = 28;
    rx_idle_pct = 65;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle block after reset gives silence with done set
    send_next();
    // zero-length note counts as ended
    send_tick(CMD_START, 31'd123, 16'd0);
    send_next();
    // single-sample note: first sample already carries done, then silence
    send_tick(CMD_START, 31'h7FFF_FFFF, 16'd1);
    send_next();
    // eighth-turn steps land on every quadrant boundary and the table ends
    send_tick(CMD_START, 31'h2000_0000, 16'd8);
    repeat (7) send_next();

    // full amplitude (bit 15 of the write must be dropped), no attack, deepest decay
    wait_drained();
    program_regs(16'hFFFF, 16'd0, 16'hFFFF);
    // largest step, phase wraps every other sample; last tick lands after the note
    send_tick(CMD_START, 31'h7FFF_FFFF, 16'd6);
    repeat (6) send_next();

    // silent amplitude, attack spanning the whole note, no decay
    wait_drained();
    program_regs(16'd0, 16'hFFFF, 16'd0);
    send_tick(CMD_START, 31'h1555_5555, 16'hFFFF);
    repeat (3) send_next();

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      int target;
      wait_drained();
      if (ph < 2) begin
        tx_idle_pct = 28;
        rx_idle_pct = 65;
      end else if (ph < 4) begin
        tx_idle_pct = 65;
        rx_idle_pct = 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_regs(pick_reg_value(16'd0, 16'd32767),
                   pick_reg_value(16'd1, 16'hFFFF),
                   pick_reg_value(16'd0, 16'hFFFF));
      // receiver stops for a long while as the sender keeps pushing, input must back up
      if (ph == 4) hold_req = 1'b1;
      target = items + ITEMS_PER_PHASE;
      while (items < target) begin
        if ($urandom_range(9) == 0) begin
          // noise: any command with any fields
          send_tick(1'($urandom_range(1)), 31'($urandom()), 16'($urandom()));
        end else begin
          send_note();
        end
      end
    end

    // drain, then leave room for any stray transaction
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_enveloped_tone_generator_top OK");
    end else begin
      $display("tb_enveloped_tone_generator_top NOT OK");
    end
    $finish;
  end

  // overall limit, far above the slowest correct run
  initial begin
    #10_000_000;
    $display("tb_enveloped_tone_generator_top NOT OK");
    $finish;
  end

endmodule
